/* rtl/core/lif_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the leaky integrate-and-fire neuron.
package lif_pkg;

	localparam int NUM_INPUTS_DEF  = 1024;
	localparam int VALUE_WIDTH_DEF = 16;

	localparam int IDX_W       = 10;
	localparam int DECAY_W     = 17;
	localparam int THRESH_W    = 16;
	localparam int SUM_GUARD   = 10;
	localparam int DECAY_FRAC  = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 17;

	localparam logic [DECAY_W-1:0]         DECAY_ONE    = 17'd65536;
	localparam logic [DECAY_W-1:0]         DECAY_RESET  = 17'd58982;
	localparam logic signed [THRESH_W-1:0] THRESH_RESET = 16'sd256;

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_SPIKE  = 2'd1,
		ACT_FINISH = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DECAY     = 1'b0,
		REG_THRESHOLD = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic was_reset;
		logic saturated;
	} flags_t;

endpackage

/* rtl/core/lif_weight_ram.sv */
`timescale 1ns / 1ps
// Synaptic weight table: one write port and one registered read port.
module lif_weight_ram #(
	parameter int DEPTH = lif_pkg::NUM_INPUTS_DEF,
	parameter int WIDTH = lif_pkg::VALUE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/lif_leak_unit.sv */
`timescale 1ns / 1ps
// Membrane update: product stage, then floor shift, saturation and result register.
module lif_leak_unit #(
	parameter int VALUE_WIDTH = lif_pkg::VALUE_WIDTH_DEF,
	parameter int SUM_W       = lif_pkg::VALUE_WIDTH_DEF + lif_pkg::SUM_GUARD
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take_valid,
	output logic                                take_ready,
	input  logic signed [VALUE_WIDTH-1:0]       membrane,
	input  logic signed [SUM_W-1:0]             spike_sum,
	input  logic [lif_pkg::DECAY_W-1:0]         decay,
	input  logic signed [lif_pkg::THRESH_W-1:0] fire_threshold,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic signed [VALUE_WIDTH-1:0]       res_membrane,
	output lif_pkg::flags_t                     res_flags
);

	localparam int CMP_W = (VALUE_WIDTH > lif_pkg::THRESH_W) ? VALUE_WIDTH : lif_pkg::THRESH_W;
	localparam int PM_W  = VALUE_WIDTH + lif_pkg::DECAY_W + 1;
	localparam int ACC_W = SUM_W + lif_pkg::DECAY_W + 1;

	logic [lif_pkg::DECAY_W-1:0]  d_clamp;
	logic [lif_pkg::DECAY_W-1:0]  one_minus;
	logic                         fired;
	logic signed [PM_W-1:0]       prod_m;
	logic signed [ACC_W-1:0]      prod_s;

	logic                         valid_s2;
	logic                         fired_s2;
	logic signed [PM_W-1:0]       prod_m_s2;
	logic signed [ACC_W-1:0]      prod_s_s2;

	logic signed [ACC_W-1:0]      acc;
	logic signed [ACC_W-1:0]      shifted;
	logic [ACC_W-VALUE_WIDTH:0]   upper;
	logic                         fits;
	logic signed [VALUE_WIDTH-1:0] clipped;

	logic                         adv_out;

	assign adv_out    = !res_valid || res_ready;
	assign take_ready = !valid_s2 || adv_out;

	assign d_clamp   = (decay > lif_pkg::DECAY_ONE) ? lif_pkg::DECAY_ONE : decay;
	assign one_minus = lif_pkg::DECAY_ONE - d_clamp;
	assign fired     = CMP_W'(membrane) > CMP_W'(fire_threshold);

	// A neuron that fired drops its leak term entirely.
	assign prod_m = fired ? PM_W'(0) : $signed({1'b0, d_clamp}) * membrane;
	assign prod_s = $signed({1'b0, one_minus}) * spike_sum;

	always_ff @(posedge clk) begin
		if (take_valid && take_ready) begin
			prod_m_s2 <= prod_m;
			prod_s_s2 <= prod_s;
			fired_s2  <= fired;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take_ready) begin
			valid_s2 <= take_valid;
		end
	end

	// Arithmetic shift right gives floor rounding for negative sums.
	assign acc     = ACC_W'(prod_m_s2) + prod_s_s2;
	assign shifted = acc >>> lif_pkg::DECAY_FRAC;
	assign upper   = shifted[ACC_W-1:VALUE_WIDTH-1];
	assign fits    = (&upper) || !(|upper);

	always_comb begin
		if (fits) begin
			clipped = shifted[VALUE_WIDTH-1:0];
		end else if (shifted[ACC_W-1]) begin
			clipped = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
		end else begin
			clipped = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && valid_s2) begin
			res_membrane        <= clipped;
			res_flags.was_reset <= fired_s2;
			res_flags.saturated <= !fits;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv_out) begin
			res_valid <= valid_s2;
		end
	end

endmodule

/* rtl/core/lif_neuron_state_update.sv */
`timescale 1ns / 1ps
// Top level of the event-driven leaky integrate-and-fire neuron update.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+------------------------------------------------
//  input    | in_valid / in_ready   | action, index, weight_value, membrane_in
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//  result   | out_valid / out_ready | new_membrane, was_reset, saturated
//
// One input transaction is taken every cycle while in_ready is high. Loads and
// spikes retire in the stage after the weight table read; a finish transaction
// passes the table read stage and the product stage, whose shift and clip feed
// the result register. Reset clears the pipeline valids and the spike sum, and sets
// the config registers to their defaults; the weight table holds garbage until
// written. The input side stalls only when a finish in the first stage, the
// product stage and the result register all hold work that cannot move.
module lif_neuron_state_update #(
	parameter int NUM_INPUTS  = lif_pkg::NUM_INPUTS_DEF,
	parameter int VALUE_WIDTH = lif_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           action,
	input  logic [lif_pkg::IDX_W-1:0]            index,
	input  logic signed [VALUE_WIDTH-1:0]        weight_value,
	input  logic signed [VALUE_WIDTH-1:0]        membrane_in,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lif_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lif_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [VALUE_WIDTH-1:0]        new_membrane,
	output logic                                 was_reset,
	output logic                                 saturated
);

	localparam int ADDR_W = $clog2(NUM_INPUTS);
	localparam int SUM_W  = VALUE_WIDTH + lif_pkg::SUM_GUARD;

	logic [lif_pkg::DECAY_W-1:0]         decay_q;
	logic signed [lif_pkg::THRESH_W-1:0] threshold_q;

	logic                          in_acc;
	logic                          in_range;
	logic [ADDR_W-1:0]             addr;

	logic                          valid_s1;
	logic [1:0]                    action_s1;
	logic                          range_s1;
	logic signed [VALUE_WIDTH-1:0] membrane_s1;
	logic signed [VALUE_WIDTH-1:0] weight_s1;

	logic signed [SUM_W-1:0]       spike_sum_q;
	logic signed [SUM_W:0]         sum_next;

	logic                          s1_is_finish;
	logic                          s1_go;
	logic                          leak_ready;
	lif_pkg::flags_t               flags;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q     <= lif_pkg::DECAY_RESET;
			threshold_q <= lif_pkg::THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lif_pkg::REG_DECAY:     decay_q     <= cfg_data[lif_pkg::DECAY_W-1:0];
				lif_pkg::REG_THRESHOLD: threshold_q <= cfg_data[lif_pkg::THRESH_W-1:0];
			endcase
		end
	end

	assign in_acc   = in_valid && in_ready;
	assign in_range = 32'(index) < NUM_INPUTS;
	assign addr     = ADDR_W'(index);

	lif_weight_ram #(
		.DEPTH (NUM_INPUTS),
		.WIDTH (VALUE_WIDTH)
	) u_weight_ram (
		.clk     (clk),
		.wr_en   (in_acc && in_range && (action == lif_pkg::ACT_LOAD)),
		.wr_addr (addr),
		.wr_data (weight_value),
		.rd_en   (in_acc),
		.rd_addr (addr),
		.rd_data (weight_s1)
	);

	// Only a finish transaction has to wait for room downstream.
	assign s1_is_finish = (action_s1 == lif_pkg::ACT_FINISH);
	assign s1_go        = valid_s1 && (!s1_is_finish || leak_ready);
	assign in_ready     = !valid_s1 || !s1_is_finish || leak_ready;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_s1   <= action;
			range_s1    <= in_range;
			membrane_s1 <= membrane_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// The sum saturates when the two top bits of the widened result differ.
	assign sum_next = (SUM_W+1)'(spike_sum_q) + (SUM_W+1)'(weight_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spike_sum_q <= '0;
		end else if (s1_go) begin
			case (action_s1)
				lif_pkg::ACT_SPIKE: begin
					if (range_s1) begin
						if (sum_next[SUM_W] == sum_next[SUM_W-1]) begin
							spike_sum_q <= sum_next[SUM_W-1:0];
						end else if (sum_next[SUM_W]) begin
							spike_sum_q <= {1'b1, {(SUM_W-1){1'b0}}};
						end else begin
							spike_sum_q <= {1'b0, {(SUM_W-1){1'b1}}};
						end
					end
				end
				lif_pkg::ACT_FINISH: spike_sum_q <= '0;
				default: ;
			endcase
		end
	end

	lif_leak_unit #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.SUM_W       (SUM_W)
	) u_leak_unit (
		.clk            (clk),
		.arst_n         (arst_n),
		.take_valid     (valid_s1 && s1_is_finish),
		.take_ready     (leak_ready),
		.membrane       (membrane_s1),
		.spike_sum      (spike_sum_q),
		.decay          (decay_q),
		.fire_threshold (threshold_q),
		.res_valid      (out_valid),
		.res_ready      (out_ready),
		.res_membrane   (new_membrane),
		.res_flags      (flags)
	);

	assign was_reset = flags.was_reset;
	assign saturated = flags.saturated;

endmodule

/* rtl/core/lif_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the neuron update block and their binding to it.
module lif_checker #(
	parameter int VALUE_WIDTH = lif_pkg::VALUE_WIDTH_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [1:0]                    action,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [VALUE_WIDTH-1:0] new_membrane,
	input logic                          was_reset,
	input logic                          saturated
);

	localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

	logic finish_acc;

	assign finish_acc = in_valid && in_ready && (action == lif_pkg::ACT_FINISH);

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			out_valid && $stable(new_membrane) && $stable(was_reset) && $stable(saturated))
		else $error("result changed while stalled");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(new_membrane == VAL_MAX) || (new_membrane == VAL_MIN))
		else $error("clipped result is not a range limit");

	// With the result side draining, a finish passes the first and product stages to out_valid.
	a_finish_latency: assert property (@(posedge clk) disable iff (!arst_n)
		finish_acc ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("finish transaction produced no result in time");

endmodule

bind lif_neuron_state_update lif_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_lif_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the leaky integrate-and-fire neuron state update.
module testbench;

	localparam int VW = lif_pkg::VALUE_WIDTH_DEF;
	localparam int NI = lif_pkg::NUM_INPUTS_DEF;
	localparam int IW = lif_pkg::IDX_W;
	localparam int CW = lif_pkg::CFG_DATA_W;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam longint SUM_MAX = (longint'(1) << (VW + lif_pkg::SUM_GUARD - 1)) - 1;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam longint OUT_MAX = (longint'(1) << (VW - 1)) - 1;
	localparam longint OUT_MIN = -OUT_MAX - 1;
	localparam int SETTLE_CYCLES = 8;
	localparam longint CYCLE_LIMIT = 600000;
	localparam int DEEP_SPIKES = 1030;

	typedef struct packed {
		logic signed [VW-1:0] new_mem;
		logic                 was_reset;
		logic                 saturated;
	} membrane_update_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_CONFIG
	} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [1:0]              act;
		logic [IW-1:0]           idx;
		logic signed [VW-1:0]    wv;
		logic signed [VW-1:0]    mem;
		logic [CW-1:0]           decay_val;
		logic [CW-1:0]           thresh_val;
		logic                    typed;
		membrane_update_t        result;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               action;
	logic [IW-1:0]            index;
	logic signed [VW-1:0]     weight_value;
	logic signed [VW-1:0]     membrane_in;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [lif_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [CW-1:0]            cfg_data;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [VW-1:0]     new_membrane;
	logic                     was_reset;
	logic                     saturated;

	// Predicted neuron state and configuration.
	logic signed [VW-1:0]     weights [NI];
	bit                       loaded [NI];
	logic [IW-1:0]            loaded_list [$];
	longint                   spike_total;
	logic [lif_pkg::DECAY_W-1:0]         decay_reg;
	logic signed [lif_pkg::THRESH_W-1:0] thresh_reg;
	membrane_update_t         pending [$];

	stim_row_t                rows [$];
	int                       errors = 0;
	int                       burst_left = 0;
	longint                   cycle_count = 0;
	int                       ready_mode = 0;
	int unsigned              ready_tick = 0;

	lif_neuron_state_update u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.index        (index),
		.weight_value (weight_value),
		.membrane_in  (membrane_in),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.new_membrane (new_membrane),
		.was_reset    (was_reset),
		.saturated    (saturated)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// The receiver picks a new stall pattern whenever the low byte of ready_tick is zero.
	always @(posedge clk) begin
		ready_tick <= ready_tick + 1;
		if (ready_tick[7:0] == 8'd0)
			ready_mode <= $urandom_range(0, 3);
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((ready_tick % 7) < 3);
		endcase
	end

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : result_check
		membrane_update_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				flag_mismatch("result with nothing pending, new_membrane", new_membrane, 0);
			end else begin
				want = pending.pop_front();
				if (new_membrane !== want.new_mem)
					flag_mismatch("new_membrane", new_membrane, want.new_mem);
				if (was_reset !== want.was_reset)
					flag_mismatch("was_reset", was_reset, want.was_reset);
				if (saturated !== want.saturated)
					flag_mismatch("saturated", saturated, want.saturated);
			end
		end
	end

	// Advances the predicted neuron by one transaction; returns 1 when it ends a step.
	function automatic bit step_neuron(input logic [1:0] act, input logic [IW-1:0] idx,
			input logic signed [VW-1:0] mem, input logic signed [VW-1:0] wv,
			output membrane_update_t upd);
		longint d;
		longint om;
		longint acc;
		longint r;
		longint s;
		bit fired;
		upd = '0;
		case (act)
			lif_pkg::ACT_LOAD: begin
				if (int'(idx) < NI) begin
					weights[idx] = wv;
					if (!loaded[idx]) begin
						loaded[idx] = 1'b1;
						loaded_list.push_back(idx);
					end
				end
				return 1'b0;
			end
			lif_pkg::ACT_SPIKE: begin
				if (int'(idx) < NI) begin
					s = spike_total + longint'(weights[idx]);
					if (s > SUM_MAX)
						s = SUM_MAX;
					if (s < SUM_MIN)
						s = SUM_MIN;
					spike_total = s;
				end
				return 1'b0;
			end
			lif_pkg::ACT_FINISH: begin
				d = (decay_reg > lif_pkg::DECAY_ONE) ? longint'(lif_pkg::DECAY_ONE)
					: longint'(decay_reg);
				om = longint'(lif_pkg::DECAY_ONE) - d;
				fired = (mem > thresh_reg);
				acc = om * spike_total;
				if (!fired)
					acc += d * longint'(mem);
				r = acc >>> lif_pkg::DECAY_FRAC;
				upd.saturated = 1'b0;
				if (r > OUT_MAX) begin
					r = OUT_MAX;
					upd.saturated = 1'b1;
				end
				if (r < OUT_MIN) begin
					r = OUT_MIN;
					upd.saturated = 1'b1;
				end
				spike_total = 0;
				upd.new_mem = r[VW-1:0];
				upd.was_reset = fired;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Offers one input transaction, with the sender's bursts and gaps.
	task automatic send_item(input logic [1:0] act, input logic [IW-1:0] idx,
			input logic signed [VW-1:0] wv, input logic signed [VW-1:0] mem,
			input bit typed, input membrane_update_t typed_upd);
		membrane_update_t upd;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 10);
			if ($urandom_range(0, 9) == 0)
				burst_left = $urandom_range(100, 300);
			else
				burst_left = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		action <= act;
		index <= idx;
		weight_value <= wv;
		membrane_in <= mem;
		do @(posedge clk); while (!in_ready);
		if (step_neuron(act, idx, mem, wv, upd))
			pending.push_back(typed ? typed_upd : upd);
	endtask

	// Lets the block drain: every pending result out, then a settling wait.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both registers back to back while the block is idle.
	task automatic configure(input logic [CW-1:0] dec, input logic [CW-1:0] thr);
		cfg_valid <= 1'b1;
		cfg_index <= lif_pkg::REG_DECAY;
		cfg_data <= dec;
		do @(posedge clk); while (!cfg_ready);
		decay_reg = dec[lif_pkg::DECAY_W-1:0];
		cfg_index <= lif_pkg::REG_THRESHOLD;
		cfg_data <= thr;
		do @(posedge clk); while (!cfg_ready);
		thresh_reg = thr[lif_pkg::THRESH_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	function automatic stim_row_t item_row(input logic [1:0] act, input logic [IW-1:0] idx,
			input logic signed [VW-1:0] wv, input logic signed [VW-1:0] mem);
		stim_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.act = act;
		row.idx = idx;
		row.wv = wv;
		row.mem = mem;
		return row;
	endfunction

	function automatic stim_row_t checked_row(input logic signed [VW-1:0] mem,
			input logic signed [VW-1:0] nm, input logic wr, input logic sat);
		stim_row_t row;
		row = item_row(lif_pkg::ACT_FINISH, '0, '0, mem);
		row.typed = 1'b1;
		row.result.new_mem = nm;
		row.result.was_reset = wr;
		row.result.saturated = sat;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(input logic [CW-1:0] dec,
			input logic [CW-1:0] thr);
		stim_row_t row;
		row = '0;
		row.kind = ROW_CONFIG;
		row.decay_val = dec;
		row.thresh_val = thr;
		return row;
	endfunction

	function automatic logic [IW-1:0] pick_loaded();
		return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
	endfunction

	function automatic logic signed [VW-1:0] pick_membrane();
		longint v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = longint'(int'($urandom_range(0, 65535))) - 32768;
			3, 4: v = longint'(thresh_reg) + int'($urandom_range(0, 4)) - 2;
			5: v = $urandom_range(0, 1) ? OUT_MAX : OUT_MIN;
			default: v = int'($urandom_range(0, 4095)) - 2048;
		endcase
		if (v > OUT_MAX)
			v = OUT_MAX;
		if (v < OUT_MIN)
			v = OUT_MIN;
		return v[VW-1:0];
	endfunction

	function automatic logic [CW-1:0] pick_decay();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return lif_pkg::DECAY_ONE;
			2: return CW'($urandom_range(65537, 131071));
			3: return CW'($urandom_range(60000, 65536));
			default: return CW'($urandom_range(0, 65536));
		endcase
	endfunction

	// Mostly whole steps (loads, spikes on written weights, finish), plus noise.
	task automatic run_phase(input int count);
		int sent;
		int pick;
		int k;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_item(ACT_UNUSED, IW'($urandom), VW'($urandom), VW'($urandom), 1'b0, '0);
			end else if (pick < 16) begin
				send_item(lif_pkg::ACT_LOAD, IW'($urandom), VW'($urandom), VW'($urandom),
					1'b0, '0);
				sent++;
			end else if (pick < 20) begin
				send_item(lif_pkg::ACT_SPIKE, pick_loaded(), VW'($urandom), VW'($urandom),
					1'b0, '0);
				sent++;
			end else if (pick < 22) begin
				settle();
			end else begin
				repeat ($urandom_range(0, 2)) begin
					send_item(lif_pkg::ACT_LOAD, IW'($urandom), VW'($urandom),
						VW'($urandom), 1'b0, '0);
					sent++;
				end
				k = $urandom_range(0, 12);
				repeat (k) begin
					send_item(lif_pkg::ACT_SPIKE, pick_loaded(), VW'($urandom),
						VW'($urandom), 1'b0, '0);
					sent++;
				end
				send_item(lif_pkg::ACT_FINISH, IW'($urandom), VW'($urandom),
					pick_membrane(), 1'b0, '0);
				sent++;
			end
		end
	endtask

	initial begin
		logic [CW-1:0] dec;
		logic [CW-1:0] thr;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = lif_pkg::ACT_LOAD;
		index = '0;
		weight_value = '0;
		membrane_in = '0;
		cfg_valid = 1'b0;
		cfg_index = lif_pkg::REG_DECAY;
		cfg_data = '0;
		out_ready = 1'b0;
		foreach (loaded[i])
			loaded[i] = 1'b0;
		spike_total = 0;
		decay_reg = lif_pkg::DECAY_RESET;
		thresh_reg = lif_pkg::THRESH_RESET;

		// Reset defaults: zero state, then a membrane above threshold.
		rows.push_back(checked_row(16'sh0000, 16'sh0000, 1'b0, 1'b0));
		rows.push_back(checked_row(16'sh7fff, 16'sh0000, 1'b1, 1'b0));
		rows.push_back(item_row(lif_pkg::ACT_LOAD, 10'd0, 16'sh7fff, 16'sh0000));
		rows.push_back(item_row(lif_pkg::ACT_LOAD, 10'h3ff, 16'sh8000, 16'sh0000));
		rows.push_back(item_row(lif_pkg::ACT_LOAD, 10'd5, 16'sh5a5a, 16'sh0000));
		rows.push_back(item_row(ACT_UNUSED, 10'h3ff, 16'shffff, 16'shffff));
		rows.push_back(item_row(lif_pkg::ACT_SPIKE, 10'd0, 16'sh0000, 16'sh0000));
		rows.push_back(item_row(lif_pkg::ACT_SPIKE, 10'h3ff, 16'sh0000, 16'sh0000));
		rows.push_back(item_row(lif_pkg::ACT_SPIKE, 10'd5, 16'sh0000, 16'sh0000));
		rows.push_back(item_row(lif_pkg::ACT_FINISH, 10'd0, 16'sh0000, 16'sh8000));
		// A membrane equal to the threshold does not fire; one above it does.
		rows.push_back(item_row(lif_pkg::ACT_FINISH, 10'd0, 16'sh0000, 16'sh0100));
		rows.push_back(checked_row(16'sh0101, 16'sh0000, 1'b1, 1'b0));
		// Zero decay, threshold at the top: the sum alone clips both ways.
		rows.push_back(cfg_row(17'd0, 17'h07fff));
		rows.push_back(item_row(lif_pkg::ACT_SPIKE, 10'd0, 16'sh0000, 16'sh0000));
		rows.push_back(item_row(lif_pkg::ACT_SPIKE, 10'd0, 16'sh0000, 16'sh0000));
		rows.push_back(checked_row(16'sh0000, 16'sh7fff, 1'b0, 1'b1));
		rows.push_back(item_row(lif_pkg::ACT_SPIKE, 10'h3ff, 16'sh0000, 16'sh0000));
		rows.push_back(item_row(lif_pkg::ACT_SPIKE, 10'h3ff, 16'sh0000, 16'sh0000));
		rows.push_back(checked_row(16'sh7fff, 16'sh8000, 1'b0, 1'b1));
		// Full decay with the lowest threshold.
		rows.push_back(cfg_row(lif_pkg::DECAY_ONE, 17'h18000));
		rows.push_back(checked_row(16'sh8000, 16'sh8000, 1'b0, 1'b0));
		rows.push_back(checked_row(16'sh8001, 16'sh0000, 1'b1, 1'b0));
		// A decay above one behaves as exactly one, so the sum drops out.
		rows.push_back(cfg_row(17'h1ffff, 17'h10000));
		rows.push_back(item_row(lif_pkg::ACT_SPIKE, 10'd0, 16'sh0000, 16'sh0000));
		rows.push_back(checked_row(16'shffff, 16'shffff, 1'b0, 1'b0));
		rows.push_back(checked_row(16'sh0001, 16'sh0000, 1'b1, 1'b0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].kind == ROW_CONFIG) begin
				settle();
				configure(rows[i].decay_val, rows[i].thresh_val);
			end else begin
				send_item(rows[i].act, rows[i].idx, rows[i].wv, rows[i].mem,
					rows[i].typed, rows[i].result);
			end
		end

		// A long step drives the spike accumulator into its clip; a tiny
		// (1 - decay) keeps the result inside the output range.
		settle();
		configure(17'd65504, 17'h07fff);
		send_item(lif_pkg::ACT_LOAD, 10'd0, 16'sh7fff, VW'($urandom), 1'b0, '0);
		repeat (DEEP_SPIKES)
			send_item(lif_pkg::ACT_SPIKE, 10'd0, VW'($urandom), VW'($urandom), 1'b0, '0);
		send_item(lif_pkg::ACT_FINISH, IW'($urandom), VW'($urandom), 16'sh0000, 1'b0, '0);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					dec = '0;
					thr = 17'h18000;
				end
				1: begin
					dec = lif_pkg::DECAY_ONE;
					thr = 17'h07fff;
				end
				default: begin
					dec = pick_decay();
					thr = {1'($urandom_range(0, 1)), 16'($urandom)};
				end
			endcase
			settle();
			configure(dec, thr);
			run_phase(75);
		end

		settle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
